### src/quaternion_to_euler_angles_top_defines.svh
// Assertion macros for the quaternion to Euler angle RTL.
// Uses the clk and arst_n names of the module that expands them.
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define Q2E_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error(msg);
`define Q2E_NEVER(lbl, cond, msg) `Q2E_ASSERT(lbl, !(cond), msg)
`else
`define Q2E_ASSERT(lbl, prop, msg)
`define Q2E_NEVER(lbl, cond, msg)
`endif
`endif

### src/q2e_pkg.sv
// Shared types, widths and the CORDIC arctangent table for the
// quaternion to Euler angle block. No dependencies.
package q2e_pkg;

	localparam int COMP_W       = 16;
	localparam int OUT_W        = 16;
	localparam int ANGLE_WIDTH  = 16;
	localparam int FRAC_BITS    = 28;
	localparam int TERM_W       = 34;
	localparam int T2_W         = FRAC_BITS + 2;
	localparam int CORD_W       = 38;
	localparam int SQ_W         = 58;
	localparam int CORDIC_STEPS = 30;
	localparam int SQRT_STEPS   = 29;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = 2;

	localparam logic signed [TERM_W-1:0] Q_ONE = TERM_W'(1) <<< FRAC_BITS;

	typedef struct packed {
		logic signed [COMP_W-1:0] w_component;
		logic signed [COMP_W-1:0] x_component;
		logic signed [COMP_W-1:0] y_component;
		logic signed [COMP_W-1:0] z_component;
	} in_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] roll_angle;
		logic signed [OUT_W-1:0] pitch_angle;
		logic signed [OUT_W-1:0] yaw_angle;
	} out_word_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] t0;
		logic signed [TERM_W-1:0] t1;
		logic signed [TERM_W-1:0] t2;
		logic signed [TERM_W-1:0] t3;
		logic signed [TERM_W-1:0] t4;
	} terms_t;

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

endpackage

### src/q2e_front.sv
// Front end: takes a quaternion word, forms the exact products and the
// five atan2 terms, clamps the pitch term. Depends on q2e_pkg.
module q2e_front import q2e_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_word_t quat,
	output logic     term_valid,
	output terms_t   terms,
	input  logic     term_ready
);

	logic signed [2*COMP_W-1:0] p_wx_s1, p_yz_s1, p_wy_s1, p_zx_s1, p_wz_s1;
	logic signed [2*COMP_W-1:0] p_xy_s1, p_xx_s1, p_yy_s1, p_zz_s1;
	logic                       v_s1_q, v_s2_q;
	terms_t                     terms_s2;
	terms_t                     terms_d;
	logic                       en;
	logic signed [TERM_W-1:0]   t2_raw;

	assign en = !v_s2_q || term_ready;
	assign full = !en;
	assign term_valid = v_s2_q;
	assign terms = terms_s2;

	always_comb begin
		terms_d.t0 = (TERM_W'(p_wx_s1) + TERM_W'(p_yz_s1)) <<< 1;
		terms_d.t1 = Q_ONE - ((TERM_W'(p_xx_s1) + TERM_W'(p_yy_s1)) <<< 1);
		t2_raw     = (TERM_W'(p_wy_s1) - TERM_W'(p_zx_s1)) <<< 1;
		terms_d.t3 = (TERM_W'(p_wz_s1) + TERM_W'(p_xy_s1)) <<< 1;
		terms_d.t4 = Q_ONE - ((TERM_W'(p_yy_s1) + TERM_W'(p_zz_s1)) <<< 1);
		if (t2_raw > Q_ONE) begin
			terms_d.t2 = Q_ONE;
		end else if (t2_raw < -Q_ONE) begin
			terms_d.t2 = -Q_ONE;
		end else begin
			terms_d.t2 = t2_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else if (en) begin
			v_s1_q <= push;
			v_s2_q <= v_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_wx_s1 <= quat.w_component * quat.x_component;
			p_yz_s1 <= quat.y_component * quat.z_component;
			p_wy_s1 <= quat.w_component * quat.y_component;
			p_zx_s1 <= quat.z_component * quat.x_component;
			p_wz_s1 <= quat.w_component * quat.z_component;
			p_xy_s1 <= quat.x_component * quat.y_component;
			p_xx_s1 <= quat.x_component * quat.x_component;
			p_yy_s1 <= quat.y_component * quat.y_component;
			p_zz_s1 <= quat.z_component * quat.z_component;
			terms_s2 <= terms_d;
		end
	end

endmodule

### src/q2e_fifo.sv
// Short queue of term words between the front end and the back end.
// Depends on q2e_pkg and the assertion macro header.
`include "quaternion_to_euler_angles_top_defines.svh"
module q2e_fifo import q2e_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_valid,
	output logic   wr_ready,
	input  terms_t wr_data,
	output logic   rd_valid,
	input  logic   rd_en,
	output terms_t rd_data
);

	terms_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               wr_en;

	assign wr_ready = count_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign wr_en    = wr_valid && wr_ready;
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (FIFO_AW+1)'(wr_en) - (FIFO_AW+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`Q2E_NEVER(a_no_overflow, count_q > (FIFO_AW+1)'(FIFO_DEPTH), "queue count over depth")
	`Q2E_NEVER(a_no_underrun, rd_en && (count_q == '0), "back end read an empty queue")
	`Q2E_ASSERT(a_count_track, count_q == $past(count_q) + (FIFO_AW+1)'($past(wr_en)) - (FIFO_AW+1)'($past(rd_en)), "queue count lost a word")

endmodule

### src/q2e_back.sv
// Back end: pipelined square root for the pitch cosine, three pipelined
// CORDIC atan2 units, angle rounding and the output register. Uses q2e_pkg.
module q2e_back import q2e_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fifo_valid,
	output logic      rd_en,
	input  terms_t    fifo_data,
	output logic      empty,
	input  logic      pop,
	output out_word_t angles
);

	localparam int NSQ = SQRT_STEPS + 1;
	localparam int NCD = CORDIC_STEPS + 1;
	localparam int ANG_SH = 32 - ANGLE_WIDTH;
	localparam logic [31:0] ROUND = (32'(1) << ANG_SH) >> 1;
	localparam logic signed [31:0] QUARTER = 32'sh4000_0000;
	localparam logic [SQ_W-1:0] N_ONE = SQ_W'(1) << (2*FRAC_BITS);

	function automatic logic [OUT_W-1:0] angle_out(input logic [31:0] a, input logic clamp);
		logic [31:0]        u;
		logic signed [31:0] s;
		logic signed [31:0] r;
		u = a + ROUND;
		s = signed'(u);
		if (clamp && (s > QUARTER)) begin
			s = QUARTER;
		end
		if (clamp && (s < -QUARTER)) begin
			s = -QUARTER;
		end
		r = s >>> ANG_SH;
		return r[OUT_W-1:0];
	endfunction

	logic                     en_b;
	logic                     ent_v_s1;
	terms_t                   ent_terms_s1;
	logic                     sq_v_s [NSQ];
	terms_t                   sq_terms_s [NSQ];
	logic [SQ_W-1:0]          sq_n_s [NSQ];
	logic [SQ_W-1:0]          sq_res_s [NSQ];
	logic [SQ_W-1:0]          sq_n_d [NSQ];
	logic [SQ_W-1:0]          sq_res_d [NSQ];
	logic signed [T2_W-1:0]   t2_narrow;
	logic signed [2*T2_W-1:0] t2_sq;
	logic                     cd_v_s [NCD];
	logic signed [CORD_W-1:0] cd_x_s [3][NCD];
	logic signed [CORD_W-1:0] cd_y_s [3][NCD];
	logic [31:0]              cd_z_s [3][NCD];
	logic                     cd_zf_s [3][NCD];
	logic signed [CORD_W-1:0] cd_x_d [3][NCD];
	logic signed [CORD_W-1:0] cd_y_d [3][NCD];
	logic [31:0]              cd_z_d [3][NCD];
	logic signed [CORD_W-1:0] pre_x [3];
	logic signed [CORD_W-1:0] pre_y [3];
	logic                     out_v_q;
	out_word_t                out_q;
	out_word_t                out_d;

	assign en_b   = !out_v_q || pop;
	assign rd_en  = en_b && fifo_valid;
	assign empty  = !out_v_q;
	assign angles = out_q;

	// Square root of 1 - t2^2, one result bit per stage.
	always_comb begin
		logic [SQ_W-1:0] bitv;
		logic [SQ_W-1:0] sum;
		t2_narrow = ent_terms_s1.t2[T2_W-1:0];
		t2_sq = t2_narrow * t2_narrow;
		sq_n_d[0]   = N_ONE - SQ_W'(unsigned'(t2_sq));
		sq_res_d[0] = '0;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			bitv = SQ_W'(1) << (2*(SQRT_STEPS-1-k));
			sum  = sq_res_s[k] + bitv;
			if (sq_n_s[k] >= sum) begin
				sq_n_d[k+1]   = sq_n_s[k] - sum;
				sq_res_d[k+1] = (sq_res_s[k] >> 1) + bitv;
			end else begin
				sq_n_d[k+1]   = sq_n_s[k];
				sq_res_d[k+1] = sq_res_s[k] >> 1;
			end
		end
	end

	// CORDIC vectoring: roll, pitch and yaw lanes in parallel.
	always_comb begin
		pre_y[0] = CORD_W'($signed(sq_terms_s[NSQ-1].t0));
		pre_x[0] = CORD_W'($signed(sq_terms_s[NSQ-1].t1));
		pre_y[1] = CORD_W'($signed(sq_terms_s[NSQ-1].t2));
		pre_x[1] = signed'(CORD_W'(sq_res_s[NSQ-1]));
		pre_y[2] = CORD_W'($signed(sq_terms_s[NSQ-1].t3));
		pre_x[2] = CORD_W'($signed(sq_terms_s[NSQ-1].t4));
		for (int c = 0; c < 3; c++) begin
			if (pre_x[c] < 0) begin
				cd_x_d[c][0] = -pre_x[c];
				cd_y_d[c][0] = -pre_y[c];
				cd_z_d[c][0] = 32'h8000_0000;
			end else begin
				cd_x_d[c][0] = pre_x[c];
				cd_y_d[c][0] = pre_y[c];
				cd_z_d[c][0] = '0;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (cd_y_s[c][i] > 0) begin
					cd_x_d[c][i+1] = cd_x_s[c][i] + (cd_y_s[c][i] >>> i);
					cd_y_d[c][i+1] = cd_y_s[c][i] - (cd_x_s[c][i] >>> i);
					cd_z_d[c][i+1] = cd_z_s[c][i] + ATAN_TAB[i];
				end else begin
					cd_x_d[c][i+1] = cd_x_s[c][i] - (cd_y_s[c][i] >>> i);
					cd_y_d[c][i+1] = cd_y_s[c][i] + (cd_x_s[c][i] >>> i);
					cd_z_d[c][i+1] = cd_z_s[c][i] - ATAN_TAB[i];
				end
			end
		end
		out_d.roll_angle  = angle_out(cd_zf_s[0][NCD-1] ? '0 : cd_z_s[0][NCD-1], 1'b0);
		out_d.pitch_angle = angle_out(cd_zf_s[1][NCD-1] ? '0 : cd_z_s[1][NCD-1], 1'b1);
		out_d.yaw_angle   = angle_out(cd_zf_s[2][NCD-1] ? '0 : cd_z_s[2][NCD-1], 1'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_v_s1 <= 1'b0;
			out_v_q  <= 1'b0;
			for (int k = 0; k < NSQ; k++) begin
				sq_v_s[k] <= 1'b0;
			end
			for (int i = 0; i < NCD; i++) begin
				cd_v_s[i] <= 1'b0;
			end
		end else if (en_b) begin
			ent_v_s1  <= fifo_valid;
			sq_v_s[0] <= ent_v_s1;
			for (int k = 1; k < NSQ; k++) begin
				sq_v_s[k] <= sq_v_s[k-1];
			end
			cd_v_s[0] <= sq_v_s[NSQ-1];
			for (int i = 1; i < NCD; i++) begin
				cd_v_s[i] <= cd_v_s[i-1];
			end
			out_v_q <= cd_v_s[NCD-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			ent_terms_s1  <= fifo_data;
			sq_terms_s[0] <= ent_terms_s1;
			for (int k = 1; k < NSQ; k++) begin
				sq_terms_s[k] <= sq_terms_s[k-1];
			end
			for (int k = 0; k < NSQ; k++) begin
				sq_n_s[k]   <= sq_n_d[k];
				sq_res_s[k] <= sq_res_d[k];
			end
			for (int c = 0; c < 3; c++) begin
				cd_zf_s[c][0] <= (pre_x[c] == '0) && (pre_y[c] == '0);
				for (int i = 1; i < NCD; i++) begin
					cd_zf_s[c][i] <= cd_zf_s[c][i-1];
				end
				for (int i = 0; i < NCD; i++) begin
					cd_x_s[c][i] <= cd_x_d[c][i];
					cd_y_s[c][i] <= cd_y_d[c][i];
					cd_z_s[c][i] <= cd_z_d[c][i];
				end
			end
			out_q <= out_d;
		end
	end

endmodule

### src/quaternion_to_euler_angles_top.sv
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on q2e_pkg, q2e_front, q2e_fifo and q2e_back.
//
// Usage: a unit quaternion word (w, x, y, z in signed Q1.14) is written with
// push while full is low. Roll, pitch and yaw come back as signed binary
// angles (32768 is pi) on angles while empty is low, and are taken with pop.
// Words leave in the order they arrived, one result per input word.
// A word passes, from the push edge until empty drops, through the product
// and term registers, the four-word queue, one entry stage, thirty square
// root stages and thirty-one CORDIC stages, then the output register.
// The pipeline takes a new word every cycle while pop keeps up.
// When pop is held low the back pipeline freezes with the result waiting;
// the queue then fills and full rises, so the front stops too.
// Reset clears all valid flags and queue pointers; the block is ready at
// once after reset with no clearing pass.
module quaternion_to_euler_angles_top import q2e_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  quat,
	output logic      empty,
	input  logic      pop,
	output out_word_t angles
);

	logic   term_valid, term_ready;
	terms_t terms;
	logic   q_valid, q_rd_en;
	terms_t q_data;

	q2e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.quat       (quat),
		.term_valid (term_valid),
		.terms      (terms),
		.term_ready (term_ready)
	);

	q2e_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (term_valid),
		.wr_ready (term_ready),
		.wr_data  (terms),
		.rd_valid (q_valid),
		.rd_en    (q_rd_en),
		.rd_data  (q_data)
	);

	q2e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (q_valid),
		.rd_en      (q_rd_en),
		.fifo_data  (q_data),
		.empty      (empty),
		.pop        (pop),
		.angles     (angles)
	);

endmodule
